// ===== rtl/wrpm_pkg.sv =====
// ----------------------------------------------------------------------------
// wrpm_pkg
// Shared types and constants for the windowed role presence map.
// ----------------------------------------------------------------------------
package wrpm_pkg;

  localparam int FACE_DEPTH_DEF     = 1024;
  localparam int SUBTITLE_DEPTH_DEF = 1024;
  localparam int MAX_ROLES_DEF      = 64;
  localparam int CNT_W              = 12;
  localparam logic [CNT_W-1:0] COUNT_MAX = 12'd4095;

  localparam logic [1:0] OP_LOAD_FACE = 2'd0;
  localparam logic [1:0] OP_LOAD_SUB  = 2'd1;
  localparam logic [1:0] OP_EVAL      = 2'd2;
  localparam logic [1:0] OP_CLEAR     = 2'd3;

  localparam logic [1:0] REG_ROLES     = 2'd0;
  localparam logic [1:0] REG_RADIUS    = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [31:0]       start_time;
    logic [31:0]       end_time;
    logic signed [7:0] role_code;
    logic [15:0]       score;
    logic              mask_bit;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  subtitle_index;
    logic [63:0] role_bitmap;
    logic        row_written;
    logic        last;
  } out_item_t;

  // Role count update request between sequencer and count table
  typedef struct packed {
    logic       valid;
    logic       inc;
    logic [7:0] role;
  } cnt_req_t;

endpackage

// ===== rtl/wrpm_counts.sv =====
// ----------------------------------------------------------------------------
// wrpm_counts
// Per-role saturating counters in a small synchronous memory, read, modified
// and written back, with a nonzero flag per role. A clear flag marks its
// count as zero whatever the memory holds, so clear and reset only zero the
// flags.
// ----------------------------------------------------------------------------
module wrpm_counts #(
  parameter int MAX_ROLES = wrpm_pkg::MAX_ROLES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  logic [6:0]         roles_in_use,
  input  wrpm_pkg::cnt_req_t req,
  output logic [63:0]        present
);
  import wrpm_pkg::*;

  localparam int RW = (MAX_ROLES > 1) ? $clog2(MAX_ROLES) : 1;

  logic [CNT_W-1:0]     cnt_mem [MAX_ROLES];
  logic [MAX_ROLES-1:0] nonzero;
  logic [CNT_W-1:0]     cnt_rd;
  logic                 pend;
  logic                 pend_inc;
  logic [RW-1:0]        pend_role;
  logic [RW-1:0]        req_slot;
  logic [CNT_W-1:0]     cnt_cur;
  logic [CNT_W-1:0]     cnt_new;
  logic [6:0]           eff;
  logic                 hit;

  // Clamp role count and qualify the request
  always_comb begin
    eff      = (roles_in_use > 7'(MAX_ROLES)) ? 7'(MAX_ROLES) : roles_in_use;
    hit      = req.valid && !req.role[7] && ({1'b0, req.role[6:0]} < {1'b0, eff});
    req_slot = req.role[RW-1:0];
  end

  // Read the addressed count; the sequencer issues requests no faster than the
  // write-backs land, so a read never meets a write-back still in flight
  always_ff @(posedge clk) begin
    cnt_rd <= cnt_mem[req_slot];
  end

  // Hold the request for the write-back cycle
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      pend <= 1'b0;
    end else begin
      pend <= hit;
    end
    pend_inc  <= req.inc;
    pend_role <= req_slot;
  end

  // Saturate both ways
  always_comb begin
    cnt_cur = nonzero[pend_role] ? cnt_rd : '0;
    if (pend_inc) begin
      cnt_new = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
    end else begin
      cnt_new = (cnt_cur == '0) ? cnt_cur : cnt_cur - 1'b1;
    end
  end

  // Write back the updated count
  always_ff @(posedge clk) begin
    if (pend) cnt_mem[pend_role] <= cnt_new;
  end

  // Track which roles hold a positive count
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      nonzero <= '0;
    end else if (pend) begin
      nonzero[pend_role] <= (cnt_new != '0);
    end
  end

  // Presence bitmap limited to roles in use
  always_comb begin
    present = '0;
    for (int i = 0; i < MAX_ROLES; i++)
      present[i] = nonzero[i] && (7'(i) < eff);
  end

endmodule

// ===== rtl/windowed_role_presence_map.sv =====
// ----------------------------------------------------------------------------
// windowed_role_presence_map
// Event stores with windowed per-role presence evaluation of subtitles.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  cmd     | start, busy, cmd                          | in (busy out)
//  result  | res_valid, res                            | out, one-cycle strobe
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in (ready out)
//
// Loads, clear and an evaluate with no subtitle left pass through S_DONE before
// the next transaction is accepted. An evaluate reads the subtitle, finds where
// each of the four pointers stops, stepping one event at a time, then settles
// the last count update, registers the result, holds the strobe and goes idle.
// Reset is synchronous and clears counts, totals and pointers; the stores
// are left as they are. The result receiver cannot stall.
module windowed_role_presence_map #(
  parameter int FACE_DEPTH     = wrpm_pkg::FACE_DEPTH_DEF,
  parameter int SUBTITLE_DEPTH = wrpm_pkg::SUBTITLE_DEPTH_DEF,
  parameter int MAX_ROLES      = wrpm_pkg::MAX_ROLES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  wrpm_pkg::in_item_t  cmd,
  output logic                res_valid,
  output wrpm_pkg::out_item_t res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import wrpm_pkg::*;

  localparam int FW = $clog2(FACE_DEPTH);
  localparam int SW = $clog2(SUBTITLE_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUB   = 3'd1;
  localparam logic [2:0] S_RDREQ = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;
  localparam logic [2:0] S_WAIT  = 3'd6;

  // Face entry: start, end, role, score. Subtitle entry: start, end, role, mask.
  logic [87:0] face_mem [FACE_DEPTH];
  logic [72:0] sub_mem  [SUBTITLE_DEPTH];
  logic [87:0] face_rd;
  logic [72:0] sub_rd;
  logic [FW-1:0] face_raddr;
  logic [SW-1:0] sub_raddr;

  logic [6:0]  roles_in_use;
  logic [23:0] window_radius;
  logic [15:0] score_threshold;

  logic [2:0]  state;
  logic [1:0]  phase;
  logic [FW:0] face_total, face_add_ptr, face_drop_ptr;
  logic [SW:0] sub_total, sub_add_ptr, sub_drop_ptr, cur_sub;
  logic [32:0] hi, lo;
  logic        cur_mask;
  logic        clear;
  cnt_req_t    req;
  logic [63:0] present;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      roles_in_use    <= 7'd64;
      window_radius   <= '0;
      score_threshold <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROLES:     roles_in_use    <= cfg_data[6:0];
        REG_RADIUS:    window_radius   <= cfg_data[23:0];
        REG_THRESHOLD: score_threshold <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Store writes on load
  always_ff @(posedge clk) begin
    if (start && !busy && cmd.op == OP_LOAD_FACE && face_total < (FW+1)'(FACE_DEPTH))
      face_mem[face_total[FW-1:0]] <= {cmd.start_time, cmd.end_time,
                                       cmd.role_code, cmd.score};
    if (start && !busy && cmd.op == OP_LOAD_SUB && sub_total < (SW+1)'(SUBTITLE_DEPTH))
      sub_mem[sub_total[SW-1:0]] <= {cmd.start_time, cmd.end_time,
                                     cmd.role_code, cmd.mask_bit};
  end

  // Synchronous store reads
  always_ff @(posedge clk) begin
    face_rd <= face_mem[face_raddr];
    sub_rd  <= sub_mem[sub_raddr];
  end

  // Read addresses follow the current walk phase
  always_comb begin
    face_raddr = (phase == 2'd0) ? face_add_ptr[FW-1:0] : face_drop_ptr[FW-1:0];
    sub_raddr  = (state == S_IDLE || state == S_SUB) ? cur_sub[SW-1:0] :
                 (phase == 2'd2) ? sub_add_ptr[SW-1:0] : sub_drop_ptr[SW-1:0];
  end

  // Walk condition for the active phase
  logic        walk_ok;
  logic        step_hit;
  logic [32:0] ev_t;
  always_comb begin
    case (phase)
      2'd0: walk_ok = face_add_ptr < face_total;
      2'd1: walk_ok = face_drop_ptr < face_total;
      2'd2: walk_ok = sub_add_ptr < sub_total;
      default: walk_ok = sub_drop_ptr < sub_total;
    endcase
    case (phase)
      2'd0: ev_t = {1'b0, face_rd[87:56]};
      2'd1: ev_t = {1'b0, face_rd[55:24]} + {9'd0, window_radius};
      2'd2: ev_t = {1'b0, sub_rd[72:41]};
      default: ev_t = {1'b0, sub_rd[40:9]} + {9'd0, window_radius};
    endcase
    step_hit = phase[0] ? (ev_t < lo) : (ev_t <= hi);
  end

  // Result strobe and count clear pulse
  always_ff @(posedge clk) begin
    res_valid <= !rst && (state == S_OUT);
    clear     <= rst || (state == S_IDLE && start && cmd.op == OP_CLEAR);
  end

  // Count update request from each walk step that hits, faces only at or above the score threshold
  always_ff @(posedge clk) begin
    req <= '{valid: !rst && state == S_CHECK && step_hit &&
                    (phase[1] || face_rd[15:0] >= score_threshold),
             inc:   !phase[0],
             role:  phase[1] ? sub_rd[8:1] : face_rd[23:16]};
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; phase <= '0;
      face_total <= '0; sub_total <= '0; cur_sub <= '0;
      face_add_ptr <= '0; face_drop_ptr <= '0;
      sub_add_ptr <= '0; sub_drop_ptr <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            case (cmd.op)
              OP_LOAD_FACE: begin
                if (face_total < (FW+1)'(FACE_DEPTH)) face_total <= face_total + 1'b1;
                state <= S_DONE;
              end
              OP_LOAD_SUB: begin
                if (sub_total < (SW+1)'(SUBTITLE_DEPTH)) sub_total <= sub_total + 1'b1;
                state <= S_DONE;
              end
              OP_CLEAR: begin
                face_total <= '0; sub_total <= '0; cur_sub <= '0;
                face_add_ptr <= '0; face_drop_ptr <= '0;
                sub_add_ptr <= '0; sub_drop_ptr <= '0;
                state <= S_DONE;
              end
              default: state <= (cur_sub < sub_total) ? S_SUB : S_DONE;
            endcase
          end
        end
        S_SUB: begin
          hi       <= {1'b0, sub_rd[40:9]} + {9'd0, window_radius};
          lo       <= {1'b0, sub_rd[72:41]};
          cur_mask <= sub_rd[0];
          phase    <= 2'd0;
          state    <= S_RDREQ;
        end
        S_RDREQ: begin
          if (walk_ok) state <= S_CHECK;
          else if (phase == 2'd3) state <= S_WAIT;
          else phase <= phase + 1'b1;
        end
        S_CHECK: begin
          if (step_hit) begin
            case (phase)
              2'd0: face_add_ptr  <= face_add_ptr + 1'b1;
              2'd1: face_drop_ptr <= face_drop_ptr + 1'b1;
              2'd2: sub_add_ptr   <= sub_add_ptr + 1'b1;
              default: sub_drop_ptr <= sub_drop_ptr + 1'b1;
            endcase
            state <= S_RDREQ;
          end else if (phase == 2'd3) begin
            state <= S_WAIT;
          end else begin
            phase <= phase + 1'b1;
            state <= S_RDREQ;
          end
        end
        // Let the last count write-back land before sampling presence
        S_WAIT: state <= S_OUT;
        S_OUT: begin
          res <= '{subtitle_index: 10'(cur_sub),
                   role_bitmap:    cur_mask ? present : '0,
                   row_written:    cur_mask,
                   last:           (cur_sub + 1'b1 == sub_total)};
          cur_sub <= cur_sub + 1'b1;
          state   <= S_DONE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  wrpm_counts #(.MAX_ROLES(MAX_ROLES)) u_counts (
    .clk(clk), .rst(rst), .clear(clear), .roles_in_use(roles_in_use),
    .req(req), .present(present)
  );

endmodule

// ===== tb/windowed_role_presence_map_test.sv =====
// ----------------------------------------------------------------------------
// windowed_role_presence_map_test
// Drives face and subtitle loads, evaluates and clears into the presence map,
// predicts every presence row from a local copy of the event stores, counts
// and pointers, and checks each result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module windowed_role_presence_map_test;
  import wrpm_pkg::*;

  localparam int FDEPTH = 1024;
  localparam int SDEPTH = 1024;
  localparam int NROLES = 64;

  // directed stimulus row; typed rows carry the known outcome
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] ts;
    logic [31:0] te;
    logic [7:0]  role;
    logic [15:0] score;
    logic        mask;
    logic        typed;
    logic        has_row;
    out_item_t   row;
  } dir_row_t;

  localparam int NDIR = 18;
  localparam dir_row_t DIR_ROWS [NDIR] = '{
    '{OP_EVAL,      32'd0, 32'd0, 8'd0, 16'd0, 1'b0, 1'b1, 1'b0, '0},
    '{OP_LOAD_FACE, 32'd0, 32'd0, 8'd0, 16'd0, 1'b0, 1'b1, 1'b0, '0},
    '{OP_LOAD_FACE, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'd63, 16'hFFFF, 1'b1, 1'b1, 1'b0, '0},
    '{OP_LOAD_FACE, 32'd5, 32'd5, 8'hFF, 16'h1234, 1'b0, 1'b1, 1'b0, '0},
    '{OP_LOAD_FACE, 32'd6, 32'd6, 8'd127, 16'h8000, 1'b0, 1'b1, 1'b0, '0},
    '{OP_LOAD_SUB,  32'd0, 32'd10, 8'd1, 16'd0, 1'b1, 1'b1, 1'b0, '0},
    '{OP_LOAD_SUB,  32'd100, 32'd200, 8'h80, 16'hFFFF, 1'b0, 1'b1, 1'b0, '0},
    '{OP_LOAD_SUB,  32'hFFFFFFFF, 32'hFFFFFFFF, 8'd63, 16'd0, 1'b1, 1'b1, 1'b0, '0},
    '{OP_EVAL,      32'd0, 32'd0, 8'd0, 16'd0, 1'b0, 1'b1, 1'b1,
      '{10'd0, 64'h3, 1'b1, 1'b0}},
    '{OP_EVAL,      32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 16'hFFFF, 1'b1, 1'b1, 1'b1,
      '{10'd1, 64'h0, 1'b0, 1'b0}},
    '{OP_EVAL,      32'd0, 32'd0, 8'd0, 16'd0, 1'b0, 1'b1, 1'b1,
      '{10'd2, 64'h8000_0000_0000_0000, 1'b1, 1'b1}},
    '{OP_EVAL,      32'd0, 32'd0, 8'd0, 16'd0, 1'b0, 1'b1, 1'b0, '0},
    '{OP_CLEAR,     32'd7, 32'd9, 8'd3, 16'd3, 1'b1, 1'b1, 1'b0, '0},
    '{OP_EVAL,      32'd0, 32'd0, 8'd0, 16'd0, 1'b0, 1'b1, 1'b0, '0},
    '{OP_LOAD_FACE, 32'd20, 32'd30, 8'd5, 16'h0001, 1'b0, 1'b0, 1'b0, '0},
    '{OP_LOAD_SUB,  32'd25, 32'd26, 8'd9, 16'd0, 1'b1, 1'b0, 1'b0, '0},
    '{OP_LOAD_SUB,  32'd40, 32'd50, 8'd9, 16'd0, 1'b1, 1'b0, 1'b0, '0},
    '{OP_EVAL,      32'd0, 32'd0, 8'd0, 16'd0, 1'b0, 1'b0, 1'b0, '0}
  };

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  in_item_t    cmd;
  logic        res_valid;
  out_item_t   res;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  windowed_role_presence_map uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .res_valid(res_valid), .res(res), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // mirror of the block's stores, counts, pointers and registers
  logic [31:0] face_start [FDEPTH];
  logic [31:0] face_end [FDEPTH];
  logic [7:0]  face_role [FDEPTH];
  logic [15:0] face_grade [FDEPTH];
  logic [31:0] sub_start [SDEPTH];
  logic [31:0] sub_end [SDEPTH];
  logic [7:0]  sub_role [SDEPTH];
  logic        sub_mask [SDEPTH];
  int unsigned presence_count [NROLES];
  int unsigned n_faces, n_subs, f_add, f_drop, s_add, s_drop, next_sub;
  logic [6:0]  roles_reg;
  logic [23:0] radius_reg;
  logic [15:0] thresh_reg;

  out_item_t   rows_due [$];
  int          errors;
  bit          quiet;
  bit          row_typed;
  bit          row_has;
  out_item_t   row_known;

  function automatic int role_slot(logic [7:0] code);
    int n;
    n = (roles_reg > NROLES) ? NROLES : roles_reg;
    if (code[7] || int'(code) >= n) return -1;
    return int'(code);
  endfunction

  function automatic void count_up(logic [7:0] code);
    int r;
    r = role_slot(code);
    if (r >= 0 && presence_count[r] < 4095) presence_count[r]++;
  endfunction

  function automatic void count_down(logic [7:0] code);
    int r;
    r = role_slot(code);
    if (r >= 0 && presence_count[r] > 0) presence_count[r]--;
  endfunction

  function automatic void wipe_map();
    for (int r = 0; r < NROLES; r++) presence_count[r] = 0;
    n_faces = 0; n_subs = 0; f_add = 0; f_drop = 0; s_add = 0; s_drop = 0;
    next_sub = 0;
  endfunction

  // advance the mirror by one command; return 1 when a row comes out
  function automatic bit presence_row(input in_item_t c, output out_item_t o);
    logic [32:0] hi;
    logic [32:0] lo;
    logic [32:0] rad;
    logic [63:0] bits;
    int          n;
    o = '0;
    case (c.op)
      OP_LOAD_FACE: begin
        if (n_faces < FDEPTH) begin
          face_start[n_faces] = c.start_time;
          face_end[n_faces] = c.end_time;
          face_role[n_faces] = c.role_code;
          face_grade[n_faces] = c.score;
          n_faces++;
        end
        return 1'b0;
      end
      OP_LOAD_SUB: begin
        if (n_subs < SDEPTH) begin
          sub_start[n_subs] = c.start_time;
          sub_end[n_subs] = c.end_time;
          sub_role[n_subs] = c.role_code;
          sub_mask[n_subs] = c.mask_bit;
          n_subs++;
        end
        return 1'b0;
      end
      OP_CLEAR: begin
        wipe_map();
        return 1'b0;
      end
      default: ;
    endcase
    if (next_sub >= n_subs) return 1'b0;
    rad = {9'd0, radius_reg};
    hi = {1'b0, sub_end[next_sub]} + rad;
    lo = {1'b0, sub_start[next_sub]};
    while (f_add < n_faces && {1'b0, face_start[f_add]} <= hi) begin
      if (face_grade[f_add] >= thresh_reg) count_up(face_role[f_add]);
      f_add++;
    end
    while (f_drop < n_faces && {1'b0, face_end[f_drop]} + rad < lo) begin
      if (face_grade[f_drop] >= thresh_reg) count_down(face_role[f_drop]);
      f_drop++;
    end
    while (s_add < n_subs && {1'b0, sub_start[s_add]} <= hi) begin
      count_up(sub_role[s_add]);
      s_add++;
    end
    while (s_drop < n_subs && {1'b0, sub_end[s_drop]} + rad < lo) begin
      count_down(sub_role[s_drop]);
      s_drop++;
    end
    bits = '0;
    if (sub_mask[next_sub]) begin
      n = (roles_reg > NROLES) ? NROLES : roles_reg;
      for (int r = 0; r < n; r++) if (presence_count[r] > 0) bits[r] = 1'b1;
    end
    o.subtitle_index = next_sub[9:0];
    o.role_bitmap = bits;
    o.row_written = sub_mask[next_sub];
    o.last = (next_sub + 1 == n_subs);
    next_sub++;
    return 1'b1;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t: %s got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  // check result strobes first, then take the accepted transaction
  always @(posedge clk) begin
    out_item_t o;
    out_item_t w;
    bit        got;
    if (!rst) begin
      if (res_valid) begin
        if (rows_due.size() == 0) begin
          report("unexpected row", 64'(res.subtitle_index), '0);
        end else begin
          w = rows_due.pop_front();
          if (res.subtitle_index !== w.subtitle_index)
            report("subtitle_index", 64'(res.subtitle_index), 64'(w.subtitle_index));
          if (res.role_bitmap !== w.role_bitmap)
            report("role_bitmap", res.role_bitmap, w.role_bitmap);
          if (res.row_written !== w.row_written)
            report("row_written", 64'(res.row_written), 64'(w.row_written));
          if (res.last !== w.last) report("last", 64'(res.last), 64'(w.last));
        end
      end
      if (start && !busy) begin
        got = presence_row(cmd, o);
        if (row_typed) begin
          if (got !== row_has) report("row present", 64'(got), 64'(row_has));
          if (row_has) rows_due.push_back(row_known);
        end else if (got) begin
          rows_due.push_back(o);
        end
      end
    end
  end

  // hold start across back-to-back transactions, drop it for idle bursts
  task automatic issue(input in_item_t c, input bit typed = 0, input bit has = 0,
                       input out_item_t known = '0);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    cmd = c;
    row_typed = typed;
    row_has = has;
    row_known = known;
    do @(posedge clk); while (busy);
  endtask

  // wait until every row has come and the block has gone idle
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    row_typed = 1'b0;
    while (rows_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ROLES:     roles_reg = val[6:0];
      REG_RADIUS:    radius_reg = val[23:0];
      REG_THRESHOLD: thresh_reg = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data = $urandom;
  endtask

  function automatic logic [7:0] pick_role();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 8'($urandom_range(128, 255));
    if (k == 1) return 8'($urandom);
    return 8'($urandom_range(0, 70));
  endfunction

  function automatic in_item_t noise_cmd();
    in_item_t c;
    c = in_item_t'($bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom}));
    return c;
  endfunction

  int sent;
  int episode;

  initial begin
    in_item_t    c;
    logic [31:0] tf;
    logic [31:0] tsub;
    int          nf;
    int          ns;
    int          lf;
    int          ls;
    start = 1'b0; cmd = '0; cfg_valid = 1'b0; cfg_index = REG_ROLES; cfg_data = '0;
    errors = 0; quiet = 1'b0; row_typed = 1'b0; row_has = 1'b0; row_known = '0;
    roles_reg = 7'd64; radius_reg = '0; thresh_reg = '0;
    sent = 0;
    episode = 0;
    wipe_map();
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rows at reset settings
    for (int i = 0; i < NDIR; i++) begin
      c = '0;
      c.op = DIR_ROWS[i].op; c.start_time = DIR_ROWS[i].ts; c.end_time = DIR_ROWS[i].te;
      c.role_code = DIR_ROWS[i].role; c.score = DIR_ROWS[i].score;
      c.mask_bit = DIR_ROWS[i].mask;
      issue(c, DIR_ROWS[i].typed, DIR_ROWS[i].has_row, DIR_ROWS[i].row);
      sent++;
    end
    drain();

    // full subtitle store: loads past the depth are dropped
    c = '0; c.op = OP_CLEAR; issue(c); sent++;
    for (int i = 0; i < 40; i++) begin
      c.op = OP_LOAD_FACE; c.start_time = 32'(i * 3); c.end_time = 32'(i * 3 + 4);
      c.role_code = 8'(i % 70); c.score = 16'($urandom); c.mask_bit = 1'($urandom);
      issue(c); sent++;
    end
    for (int i = 0; i < SDEPTH + 2; i++) begin
      c.op = OP_LOAD_SUB; c.start_time = 32'(i * 3); c.end_time = 32'(i * 3 + 2);
      c.role_code = 8'(i % 70); c.mask_bit = 1'(i % 5 != 0);
      issue(c); sent++;
    end
    for (int i = 0; i < 6; i++) begin
      c = '0; c.op = OP_EVAL; issue(c); sent++;
    end
    drain();

    // random episodes of well-formed load and evaluate sequences
    while (sent < 1850) begin
      quiet = (sent > 1650) || ($urandom_range(0, 5) == 0);
      drain();
      case (episode % 6)
        0: begin
          write_reg(REG_ROLES, 32'd1); write_reg(REG_RADIUS, 32'd0);
          write_reg(REG_THRESHOLD, 32'd0);
        end
        1: begin
          write_reg(REG_ROLES, 32'd127); write_reg(REG_RADIUS, 32'hFFFFFFFF);
          write_reg(REG_THRESHOLD, 32'hFFFF);
        end
        2: write_reg(REG_ROLES, {$urandom_range(0, 1) ? 25'h1FFFFFF : 25'd0, 7'd0});
        3: write_reg(REG_ROLES, 32'd64);
        default: begin
          write_reg(REG_ROLES, 32'($urandom_range(1, 80)) | ($urandom & 32'hFFFFFF80));
          write_reg(REG_RADIUS, $urandom_range(0, 1) ? 32'($urandom_range(0, 40)) : $urandom);
          write_reg(REG_THRESHOLD, $urandom);
        end
      endcase
      episode++;
      if ($urandom_range(0, 7) != 0) begin
        c = noise_cmd(); c.op = OP_CLEAR; issue(c); sent++;
      end
      case ($urandom_range(0, 3))
        0: tf = 32'hFFFFFE00 + $urandom_range(0, 255);
        1: tf = $urandom_range(0, 60);
        default: tf = $urandom;
      endcase
      tsub = tf;
      nf = $urandom_range(0, 14);
      ns = $urandom_range(1, 10);
      lf = 0; ls = 0;
      while (lf < nf || ls < ns) begin
        c = noise_cmd();
        if ($urandom_range(0, 19) == 0) begin
          // stray command with random content
        end else if (ls >= ns || (lf < nf && $urandom_range(0, 1) == 0)) begin
          c.op = OP_LOAD_FACE; c.start_time = tf;
          c.end_time = (tf > 32'hFFFFFFC0) ? 32'hFFFFFFFF : tf + $urandom_range(0, 40);
          c.role_code = pick_role();
          tf = (tf > 32'hFFFFFFE0) ? tf : tf + $urandom_range(0, 25);
          lf++;
        end else begin
          c.op = OP_LOAD_SUB; c.start_time = tsub;
          c.end_time = (tsub > 32'hFFFFFFC0) ? 32'hFFFFFFFF : tsub + $urandom_range(0, 30);
          c.role_code = pick_role();
          tsub = (tsub > 32'hFFFFFFE0) ? tsub : tsub + $urandom_range(0, 30);
          ls++;
        end
        issue(c); sent++;
      end
      for (int i = 0; i < ns + $urandom_range(0, 1); i++) begin
        if ($urandom_range(0, 14) == 0) begin
          // settings change between evaluates once the block is idle
          drain();
          write_reg(2'($urandom_range(0, 2)), $urandom_range(0, 1) ? $urandom
                    : 32'($urandom_range(0, 30)));
        end
        c = noise_cmd(); c.op = OP_EVAL; issue(c); sent++;
      end
    end

    @(negedge clk);
    start = 1'b0;
    while (rows_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("windowed_role_presence_map: match");
    end else begin
      $display("windowed_role_presence_map: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #60_000_000;
    $display("windowed_role_presence_map: mismatch");
    $finish;
  end

endmodule
